### src/bpa_pkg.sv
// Shared constants, codes and types of the buddy page allocator.
package bpa_pkg;

    localparam int MAX_ORDER = 10;
    localparam int PAGE_BITS = 16;
    localparam int LEVELS    = MAX_ORDER + 1;
    localparam int ORD_W     = 4;
    localparam int CNT_W     = PAGE_BITS + 1;

    localparam logic [1:0] OP_ALLOC = 2'd0;
    localparam logic [1:0] OP_FREE  = 2'd1;
    localparam logic [1:0] OP_ADD   = 2'd2;
    localparam logic [1:0] OP_NOP   = 2'd3;

    localparam logic [1:0] STS_OK    = 2'd0;
    localparam logic [1:0] STS_OOM   = 2'd1;
    localparam logic [1:0] STS_DUP   = 2'd2;
    localparam logic [1:0] STS_RANGE = 2'd3;

    typedef struct packed {
        logic             free;
        logic [ORD_W-1:0] order;
    } meta_t;

endpackage

### src/buddy_page_allocator.sv
// Buddy page allocator: sequencer over page metadata and free-list link memories.
//
// One request at a time. The state lives in three single-port-read memories (page
// order/free mark, next link, prev link), each with a registered read, plus small
// head/tail/length registers per order. Allocate unlinks the head of the smallest
// fitting list and splits it one level per step down to the requested order; free
// checks that the page is not already free, then reads each buddy and merges while
// the buddy is free at the same order; add region places one aligned block per step;
// requests rejected at acceptance and no-ops go straight to the result. Every memory
// read is followed by a state of its own. The sequencer returns to idle before the
// next request is accepted, and a full output register holds the sequencer until the
// waiting result leaves. After reset a clearing pass writes all 65536 metadata
// entries, one per cycle, and no request is accepted until the pass ends. The
// page_count register should be written only while no request is in flight.
module buddy_page_allocator
    import bpa_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // order[3:0], page[19:4], region_pages[36:20], zeros
    input  logic [1:0]  s_tuser,   // op[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // page_res[15:0], order_res[19:16], zeros
    output logic [1:0]  m_tuser,   // status[1:0]
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [16:0] cfg_data
);

    localparam logic [3:0] ST_CLR      = 4'd0;
    localparam logic [3:0] ST_IDLE     = 4'd1;
    localparam logic [3:0] ST_AL_SPLIT = 4'd2;
    localparam logic [3:0] ST_FR_CHK   = 4'd3;
    localparam logic [3:0] ST_FR_LOOP  = 4'd4;
    localparam logic [3:0] ST_FR_BUD   = 4'd5;
    localparam logic [3:0] ST_FR_MRG   = 4'd6;
    localparam logic [3:0] ST_FR_END   = 4'd7;
    localparam logic [3:0] ST_RG_LOOP  = 4'd8;
    localparam logic [3:0] ST_RG_ADD   = 4'd9;
    localparam logic [3:0] ST_DROP_RD  = 4'd10;
    localparam logic [3:0] ST_DROP_WR  = 4'd11;
    localparam logic [3:0] ST_DONE     = 4'd12;

    localparam logic [CNT_W-1:0] PAGES = CNT_W'(1) << PAGE_BITS;

    meta_t                meta_mem [1 << PAGE_BITS];
    logic [PAGE_BITS-1:0] next_mem [1 << PAGE_BITS];
    logic [PAGE_BITS-1:0] prev_mem [1 << PAGE_BITS];

    logic [PAGE_BITS-1:0] head_reg [LEVELS];
    logic [PAGE_BITS-1:0] tail_reg [LEVELS];
    logic [CNT_W-1:0]     len_reg  [LEVELS];

    logic [3:0]           state_reg;
    logic [PAGE_BITS-1:0] clr_cnt_reg;
    logic [CNT_W-1:0]     pc_reg;
    logic [ORD_W-1:0]     ord_reg, cur_reg, lv_reg, o_reg;
    logic [PAGE_BITS-1:0] h_reg, idx_reg, bud_reg, x_reg;
    logic                 ret_free_reg;
    logic [CNT_W-1:0]     a_reg;
    logic [CNT_W:0]       end_reg;
    logic [1:0]           rstat_reg;
    logic [1:0]           res_sts_reg;
    logic [PAGE_BITS-1:0] res_pg_reg;
    logic [ORD_W-1:0]     res_ord_reg;
    logic                 m_valid_reg;
    logic [1:0]           m_sts_reg;
    logic [PAGE_BITS-1:0] m_pg_reg;
    logic [ORD_W-1:0]     m_ord_reg;

    meta_t                meta_q;
    logic [PAGE_BITS-1:0] next_q, prev_q;

    logic [1:0]           in_op;
    logic [ORD_W-1:0]     in_ord;
    logic [PAGE_BITS-1:0] in_page;
    logic [CNT_W-1:0]     in_len;
    logic [CNT_W-1:0]     eff_cnt;
    logic [CNT_W:0]       in_end;
    logic                 s_acc;

    logic                 found;
    logic [ORD_W-1:0]     found_lv;
    logic [ORD_W-1:0]     o_calc;
    logic [PAGE_BITS-1:0] bud_calc;

    logic                 push_en;
    logic [ORD_W-1:0]     push_lv;
    logic [PAGE_BITS-1:0] push_x;

    logic                 meta_we;
    logic [PAGE_BITS-1:0] meta_wa, meta_ra;
    meta_t                meta_wd;
    logic                 next_we, prev_we;
    logic [PAGE_BITS-1:0] next_wa, next_wd, prev_wa, prev_wd;

    assign in_op   = s_tuser[1:0];
    assign in_ord  = s_tdata[3:0];
    assign in_page = s_tdata[19:4];
    assign in_len  = s_tdata[36:20];
    assign in_end  = {2'b00, in_page} + {1'b0, in_len};
    assign eff_cnt = (pc_reg > PAGES) ? PAGES : pc_reg;

    assign s_tready  = (state_reg == ST_IDLE);
    assign s_acc     = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_valid_reg;
    assign m_tuser   = m_sts_reg;
    assign m_tdata   = {4'd0, m_ord_reg, m_pg_reg};

    // Smallest non-empty list at or above the requested order.
    always_comb begin
        found    = 1'b0;
        found_lv = '0;
        for (int k = MAX_ORDER; k >= 0; k--) begin
            if ((ORD_W'(k) >= in_ord) && (len_reg[k] != '0)) begin
                found    = 1'b1;
                found_lv = ORD_W'(k);
            end
        end
    end

    // Largest aligned block at a_reg that still fits below the region end.
    always_comb begin
        o_calc = '0;
        for (int k = 1; k <= MAX_ORDER; k++) begin
            if (((a_reg & ((CNT_W'(1) << k) - CNT_W'(1))) == '0) &&
                (({1'b0, a_reg} + ((CNT_W+1)'(1) << k)) <= end_reg)) begin
                o_calc = ORD_W'(k);
            end
        end
    end

    assign bud_calc = idx_reg ^ (PAGE_BITS'(1) << cur_reg);

    always_comb begin
        push_en = 1'b0;
        push_lv = '0;
        push_x  = '0;
        case (state_reg)
            ST_AL_SPLIT: begin
                if (cur_reg > ord_reg) begin
                    push_en = 1'b1;
                    push_lv = cur_reg - 1'b1;
                    push_x  = h_reg ^ (PAGE_BITS'(1) << (cur_reg - 1'b1));
                end
            end
            ST_FR_END: begin
                push_en = 1'b1;
                push_lv = cur_reg;
                push_x  = idx_reg;
            end
            ST_RG_ADD: begin
                if (!meta_q.free) begin
                    push_en = 1'b1;
                    push_lv = o_reg;
                    push_x  = a_reg[PAGE_BITS-1:0];
                end
            end
            default: ;
        endcase
    end

    always_comb begin
        meta_we = 1'b0;
        meta_wa = '0;
        meta_wd = '0;
        meta_ra = '0;
        case (state_reg)
            ST_CLR: begin
                meta_we = 1'b1;
                meta_wa = clr_cnt_reg;
            end
            ST_IDLE: meta_ra = in_page;
            ST_AL_SPLIT: begin
                meta_we = 1'b1;
                if (cur_reg > ord_reg) begin
                    meta_wa = push_x;
                    meta_wd = '{free: 1'b1, order: cur_reg - 1'b1};
                end else begin
                    meta_wa = h_reg;
                    meta_wd = '{free: 1'b0, order: ord_reg};
                end
            end
            ST_FR_LOOP: meta_ra = bud_calc;
            ST_FR_MRG: begin
                meta_we = !(bud_reg < idx_reg);
                meta_wa = bud_reg;
                meta_wd = '{free: 1'b0, order: cur_reg};
            end
            ST_FR_END: begin
                meta_we = 1'b1;
                meta_wa = idx_reg;
                meta_wd = '{free: 1'b1, order: cur_reg};
            end
            ST_RG_LOOP: meta_ra = a_reg[PAGE_BITS-1:0];
            ST_RG_ADD: begin
                meta_we = !meta_q.free;
                meta_wa = a_reg[PAGE_BITS-1:0];
                meta_wd = '{free: 1'b1, order: o_reg};
            end
            default: ;
        endcase
    end

    // Link writes come from a list append or from the unlink step, never both.
    always_comb begin
        next_we = 1'b0;
        next_wa = '0;
        next_wd = '0;
        prev_we = 1'b0;
        prev_wa = '0;
        prev_wd = '0;
        if (push_en) begin
            next_we = (len_reg[push_lv] != '0);
            next_wa = tail_reg[push_lv];
            next_wd = push_x;
            prev_we = (len_reg[push_lv] != '0);
            prev_wa = push_x;
            prev_wd = tail_reg[push_lv];
        end else if (state_reg == ST_DROP_WR) begin
            next_we = (x_reg != head_reg[lv_reg]);
            next_wa = prev_q;
            next_wd = next_q;
            prev_we = (x_reg != tail_reg[lv_reg]);
            prev_wa = next_q;
            prev_wd = prev_q;
        end
    end

    always_ff @(posedge aclk) begin
        if (meta_we) meta_mem[meta_wa] <= meta_wd;
        meta_q <= meta_mem[meta_ra];
        if (next_we) next_mem[next_wa] <= next_wd;
        if (prev_we) prev_mem[prev_wa] <= prev_wd;
        next_q <= next_mem[x_reg];
        prev_q <= prev_mem[x_reg];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLR;
            clr_cnt_reg <= '0;
            pc_reg      <= PAGES;
            m_valid_reg <= 1'b0;
            for (int k = 0; k < LEVELS; k++) len_reg[k] <= '0;
        end else begin
            if (cfg_valid) pc_reg <= cfg_data;
            // In the done state the output register is reloaded below instead.
            if (m_valid_reg && m_tready && (state_reg != ST_DONE)) m_valid_reg <= 1'b0;

            if (push_en) begin
                if (len_reg[push_lv] == '0) head_reg[push_lv] <= push_x;
                tail_reg[push_lv] <= push_x;
                len_reg[push_lv]  <= len_reg[push_lv] + 1'b1;
            end

            case (state_reg)
                ST_CLR: begin
                    clr_cnt_reg <= clr_cnt_reg + 1'b1;
                    if (clr_cnt_reg == '1) state_reg <= ST_IDLE;
                end
                ST_IDLE: begin
                    if (s_acc) begin
                        ord_reg     <= in_ord;
                        res_sts_reg <= STS_OK;
                        res_pg_reg  <= '0;
                        res_ord_reg <= '0;
                        case (in_op)
                            OP_ALLOC: begin
                                if ((in_ord > ORD_W'(MAX_ORDER)) || !found) begin
                                    res_sts_reg <= STS_OOM;
                                    state_reg   <= ST_DONE;
                                end else begin
                                    h_reg        <= head_reg[found_lv];
                                    x_reg        <= head_reg[found_lv];
                                    cur_reg      <= found_lv;
                                    lv_reg       <= found_lv;
                                    ret_free_reg <= 1'b0;
                                    state_reg    <= ST_DROP_RD;
                                end
                            end
                            OP_FREE: begin
                                idx_reg <= in_page;
                                if ({1'b0, in_page} >= eff_cnt) begin
                                    res_sts_reg <= STS_RANGE;
                                    state_reg   <= ST_DONE;
                                end else begin
                                    state_reg <= ST_FR_CHK;
                                end
                            end
                            OP_ADD: begin
                                a_reg     <= {1'b0, in_page};
                                end_reg   <= in_end;
                                rstat_reg <= STS_OK;
                                if (in_end > {1'b0, eff_cnt}) begin
                                    res_sts_reg <= STS_RANGE;
                                    state_reg   <= ST_DONE;
                                end else begin
                                    state_reg <= ST_RG_LOOP;
                                end
                            end
                            default: state_reg <= ST_DONE;
                        endcase
                    end
                end
                ST_DROP_RD: state_reg <= ST_DROP_WR;
                ST_DROP_WR: begin
                    if (x_reg == head_reg[lv_reg]) head_reg[lv_reg] <= next_q;
                    if (x_reg == tail_reg[lv_reg]) tail_reg[lv_reg] <= prev_q;
                    if (len_reg[lv_reg] != '0) len_reg[lv_reg] <= len_reg[lv_reg] - 1'b1;
                    state_reg <= ret_free_reg ? ST_FR_MRG : ST_AL_SPLIT;
                end
                ST_AL_SPLIT: begin
                    if (cur_reg > ord_reg) begin
                        cur_reg <= cur_reg - 1'b1;
                    end else begin
                        res_pg_reg  <= h_reg;
                        res_ord_reg <= ord_reg;
                        state_reg   <= ST_DONE;
                    end
                end
                ST_FR_CHK: begin
                    if (meta_q.free) begin
                        res_sts_reg <= STS_DUP;
                        state_reg   <= ST_DONE;
                    end else begin
                        cur_reg   <= meta_q.order;
                        state_reg <= ST_FR_LOOP;
                    end
                end
                ST_FR_LOOP: begin
                    bud_reg <= bud_calc;
                    if ((cur_reg >= ORD_W'(MAX_ORDER)) || ({1'b0, bud_calc} >= eff_cnt)) begin
                        state_reg <= ST_FR_END;
                    end else begin
                        state_reg <= ST_FR_BUD;
                    end
                end
                ST_FR_BUD: begin
                    if (meta_q.free && (meta_q.order == cur_reg)) begin
                        x_reg        <= bud_reg;
                        lv_reg       <= cur_reg;
                        ret_free_reg <= 1'b1;
                        state_reg    <= ST_DROP_RD;
                    end else begin
                        state_reg <= ST_FR_END;
                    end
                end
                ST_FR_MRG: begin
                    if (bud_reg < idx_reg) idx_reg <= bud_reg;
                    cur_reg   <= cur_reg + 1'b1;
                    state_reg <= ST_FR_LOOP;
                end
                ST_FR_END: begin
                    res_ord_reg <= cur_reg;
                    state_reg   <= ST_DONE;
                end
                ST_RG_LOOP: begin
                    o_reg <= o_calc;
                    if ({1'b0, a_reg} >= end_reg) begin
                        res_sts_reg <= rstat_reg;
                        state_reg   <= ST_DONE;
                    end else begin
                        state_reg <= ST_RG_ADD;
                    end
                end
                ST_RG_ADD: begin
                    if (meta_q.free) rstat_reg <= STS_DUP;
                    a_reg     <= a_reg + (CNT_W'(1) << o_reg);
                    state_reg <= ST_RG_LOOP;
                end
                ST_DONE: begin
                    if (!m_valid_reg || m_tready) begin
                        m_valid_reg <= 1'b1;
                        m_sts_reg   <= res_sts_reg;
                        m_pg_reg    <= res_pg_reg;
                        m_ord_reg   <= res_ord_reg;
                        state_reg   <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // Splitting never goes below the requested order.
    a_split_floor: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_AL_SPLIT) |-> (cur_reg >= ord_reg))
        else $error("split went below requested order");

    // A merge walk never climbs past the top order.
    a_merge_top: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FR_LOOP) |-> (cur_reg <= ORD_W'(MAX_ORDER)))
        else $error("merge order beyond top");

    // Failed requests carry no page and no order.
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && (m_sts_reg != STS_OK)) |-> (m_pg_reg == '0 && m_ord_reg == '0))
        else $error("error result with nonzero fields");

    // The unlink step always returns to the walk that started it.
    a_drop_ret: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DROP_WR) |=> (state_reg == ST_FR_MRG || state_reg == ST_AL_SPLIT))
        else $error("unlink did not return to its walk");

endmodule
